// File: design/stc_pkg.sv
// Shared types and constants for the strip-to-triangle-list converter.
`timescale 1ns / 1ps

package stc_pkg;

    // Width of an index on the stream ports
    localparam int unsigned DATA_W = 32;

    // Number of indices produced for one request
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_LIST = 2'd1;
    localparam logic [1:0] CNT_TRI  = 2'd3;

    // Result of one accepted request, handed to the output buffer
    typedef struct packed {
        logic [1:0]        count;
        logic [DATA_W-1:0] idx0;
        logic [DATA_W-1:0] idx1;
        logic [DATA_W-1:0] idx2;
    } t_tri;

endpackage

// File: design/stc_window.sv
// Strip history, winding flag and triangle decision for each accepted request.
`timescale 1ns / 1ps

module stc_window #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_wide,
    input  logic [stc_pkg::DATA_W-1:0] i_index,
    input  logic                      i_seg,
    input  logic                      i_list,
    output stc_pkg::t_tri             o_tri
);

    localparam int unsigned W = INDEX_WIDTH;

    // Two most recent strip indices (older one first) and winding flag
    logic [W-1:0] r_h0, r_h1;
    logic         r_flip;
    logic [W-1:0] n_h0, n_h1;
    logic         n_flip;

    logic [W-1:0] mask;
    logic [W-1:0] idx;
    logic [W-1:0] base_h0, base_h1;
    logic         base_flip;
    logic [W-1:0] a, b;
    logic         restart;
    logic         degen;

    // Mask of the selected index width; restart value is all ones under it
    assign mask = i_wide ? {W{1'b1}} : W'(16'hFFFF);
    assign idx  = i_index[W-1:0] & mask;

    // Segment start clears history before this index
    assign base_h0   = i_seg ? {W{1'b1}} : r_h0;
    assign base_h1   = i_seg ? {W{1'b1}} : r_h1;
    assign base_flip = i_seg ? 1'b0 : r_flip;

    assign a = base_h0 & mask;
    assign b = base_h1 & mask;

    assign restart = (a == mask) || (b == mask) || (idx == mask);
    assign degen   = (a == b) || (a == idx) || (b == idx);

    // Decide the result and the next state
    always_comb begin
        o_tri.count = stc_pkg::CNT_NONE;
        o_tri.idx0  = stc_pkg::DATA_W'(idx);
        o_tri.idx1  = stc_pkg::DATA_W'(a);
        o_tri.idx2  = stc_pkg::DATA_W'(idx);
        n_h0        = base_h0;
        n_h1        = base_h1;
        n_flip      = base_flip;
        if (i_list) begin
            o_tri.count = stc_pkg::CNT_LIST;
        end else begin
            n_h0 = base_h1;
            n_h1 = idx;
            if (restart) begin
                n_flip = 1'b0;
            end else if (!degen) begin
                o_tri.count = stc_pkg::CNT_TRI;
                // Odd triangles swap their first two corners
                o_tri.idx0  = stc_pkg::DATA_W'(base_flip ? b : a);
                o_tri.idx1  = stc_pkg::DATA_W'(base_flip ? a : b);
                n_flip      = !base_flip;
            end
        end
    end

    // Advance state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0   <= {W{1'b1}};
            r_h1   <= {W{1'b1}};
            r_flip <= 1'b0;
        end else if (i_accept) begin
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_flip <= n_flip;
        end
    end

`ifndef ASSERT_OFF
    // A produced triangle never repeats a corner
    a_tri_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tri.count == stc_pkg::CNT_TRI) |->
            (o_tri.idx0 != o_tri.idx1) && (o_tri.idx0 != o_tri.idx2)
            && (o_tri.idx1 != o_tri.idx2))
        else $error("stc_window: triangle with repeated corner");

    // A triangle never carries the restart value
    a_tri_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tri.count == stc_pkg::CNT_TRI) |->
            (o_tri.idx2[W-1:0] != mask) && (o_tri.idx0[W-1:0] != mask)
            && (o_tri.idx1[W-1:0] != mask))
        else $error("stc_window: triangle holds restart value");

    // A strip restart leaves the winding flag cleared
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_list && restart) |=> !r_flip)
        else $error("stc_window: winding kept across restart");
`endif

endmodule

// File: design/stc_emit.sv
// Buffers a request's up to three indices, sent one per cycle while ready.
`timescale 1ns / 1ps

module stc_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  stc_pkg::t_tri              i_tri,
    output logic                       o_can_load,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [stc_pkg::DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic [1:0]                r_cnt;
    logic [stc_pkg::DATA_W-1:0] r_i0, r_i1, r_i2;
    logic                      pop;

    assign pop           = (r_cnt != stc_pkg::CNT_NONE) && m_axis_tready;
    assign o_can_load    = (r_cnt == stc_pkg::CNT_NONE)
                        || ((r_cnt == stc_pkg::CNT_LIST) && m_axis_tready);
    assign m_axis_tvalid = (r_cnt != stc_pkg::CNT_NONE);
    assign m_axis_tlast  = (r_cnt == stc_pkg::CNT_LIST);
    assign m_axis_tdata  = r_i0;

    // Count of indices still to send
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= stc_pkg::CNT_NONE;
        end else if (i_load) begin
            r_cnt <= i_tri.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Load a new result or shift the next index forward
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_i0 <= i_tri.idx0;
            r_i1 <= i_tri.idx1;
            r_i2 <= i_tri.idx2;
        end else if (pop) begin
            r_i0 <= r_i1;
            r_i1 <= r_i2;
        end
    end

`ifndef ASSERT_OFF
    // A load never overwrites indices that are still to be sent
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == stc_pkg::CNT_NONE)
                 || ((r_cnt == stc_pkg::CNT_LIST) && m_axis_tready)))
        else $error("stc_emit: pending indices overwritten");

    // Only one-index or three-index results are ever buffered
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_tri.count != stc_pkg::CNT_NONE)) |=>
            ((r_cnt == stc_pkg::CNT_LIST) || (r_cnt == stc_pkg::CNT_TRI)))
        else $error("stc_emit: bad result count");

    // A sent last index empties the buffer unless a new result came in
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && m_axis_tlast && !i_load) |=> !m_axis_tvalid)
        else $error("stc_emit: indices after last of run");
`endif

endmodule

// File: design/strip_to_triangle_list_core.sv
// Top level of the triangle-strip to triangle-list converter with restart.
`timescale 1ns / 1ps

// Converts a stream of strip vertex indices, with primitive restart, into a
// triangle list; list indices pass through. Each request is decided in the
// cycle it is accepted and its result appears on the output the next cycle.
// A strip index that completes a triangle yields three indices, sent one per
// cycle while the output is ready from a three-entry result buffer; list and
// other strip requests sustain one per cycle while the output is ready. The
// next request is taken in the same cycle the last buffered index is taken
// downstream. The restart value is all ones at the selected width (16 bits,
// or INDEX_WIDTH when wide_index is set); output indices are zero-extended
// to 32 bits. Write wide_index only while the block is idle.
module strip_to_triangle_list_core #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: bit 0 = wide_index
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_data,
    // Input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [stc_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] in_index
    input  logic [1:0]                 s_axis_tuser,  // [0] starts_segment, [1] is_list
    // Output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [stc_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_index
    output logic                       m_axis_tlast   // last_of_run
);

    logic          r_wide;
    logic          accept;
    logic          can_load;
    stc_pkg::t_tri tri_res;

    // Hold the index width select
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (i_cfg_valid) begin
            r_wide <= i_cfg_data;
        end
    end

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    stc_window #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_wide   (r_wide),
        .i_index  (s_axis_tdata),
        .i_seg    (s_axis_tuser[0]),
        .i_list   (s_axis_tuser[1]),
        .o_tri    (tri_res)
    );

    stc_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_tri         (tri_res),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/sv/strip_to_triangle_list_core_tb.sv
// Self-checking testbench for the strip-to-triangle-list converter core.
`timescale 1ns / 1ps

module strip_to_triangle_list_core_tb;

    localparam int unsigned IDX_W       = 32;
    localparam logic [31:0] ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] WIDE_MASK   = 32'((64'd1 << IDX_W) - 64'd1);
    localparam logic [31:0] NARROW_MASK = 32'h0000_FFFF;
    localparam bit          MODE_NARROW = 1'b0;
    localparam bit          MODE_WIDE   = 1'b1;
    localparam int          ITEMS_PER_PHASE = 51;
    localparam int          NUM_PHASES      = 6;

    // Result counts as the block defines them
    localparam logic [1:0]  CNT_NONE = stc_pkg::CNT_NONE;
    localparam logic [1:0]  CNT_LIST = stc_pkg::CNT_LIST;
    localparam logic [1:0]  CNT_TRI  = stc_pkg::CNT_TRI;

    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_NARROW,
        CFG_WIDE
    } t_cfg_act;

    // One directed request; typed rows carry their own expected indices
    typedef struct {
        logic [31:0] idx;
        logic        seg;
        logic        lst;
        t_cfg_act    cfg;
        bit          typed;
        logic [1:0]  cnt;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] e2;
    } t_dir_row;

    typedef struct {
        logic [31:0] idx;
        logic        last;
    } t_out_rec;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Side information travelling with the request on the bus
    bit          cur_typed = 1'b0;
    logic [1:0]  cur_cnt   = CNT_NONE;
    logic [31:0] cur_e0    = '0;
    logic [31:0] cur_e1    = '0;
    logic [31:0] cur_e2    = '0;

    // Converter state as predicted
    logic [31:0] hist [3];
    logic        flip_odd;
    logic        mode_wide;
    t_out_rec    owed_indices [$];
    t_out_rec    got_rec;
    int          n_err = 0;

    int          src_idle_pct  = 25;
    int          sink_idle_pct = 76;
    bit          drv_wide      = MODE_WIDE;
    logic [31:0] strip_base    = 32'd100;

    t_dir_row dir_rows [26] = '{
        '{32'h0,        1'b0, 1'b1, CFG_KEEP,   1'b1, CNT_LIST, 32'h0, 32'h0, 32'h0},
        '{ONES,         1'b0, 1'b1, CFG_KEEP,   1'b1, CNT_LIST, ONES,  32'h0, 32'h0},
        '{32'h0,        1'b1, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h1,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h2,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_TRI,  32'h0, 32'h1, 32'h2},
        // odd triangle: first two swapped
        '{32'h3,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_TRI,  32'h2, 32'h1, 32'h3},
        // restart in the strip
        '{ONES,         1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h5,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h6,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h7,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_TRI,  32'h5, 32'h6, 32'h7},
        // degenerate windows keep the winding
        '{32'h7,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h8,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h9,        1'b0, 1'b0, CFG_KEEP,   1'b0, CNT_NONE, 32'h0, 32'h0, 32'h0},
        // list index inside a strip
        '{32'h1234_5678, 1'b0, 1'b1, CFG_KEEP,  1'b0, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'hA,        1'b1, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'hFFFF_FFFE, 1'b0, 1'b0, CFG_KEEP,  1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, CFG_KEEP,  1'b1, CNT_TRI,
          32'hA, 32'hFFFF_FFFE, 32'h8000_0000},
        // segment start on a list index
        '{32'hAAAA_AAAA, 1'b1, 1'b1, CFG_KEEP,  1'b0, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h1,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        // narrow mode: upper bits masked, restart is 0xFFFF
        '{32'h1234_FFFF, 1'b0, 1'b0, CFG_NARROW, 1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'hABCD_0001, 1'b0, 1'b0, CFG_KEEP,  1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h0002_0002, 1'b0, 1'b0, CFG_KEEP,  1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0},
        '{32'h3,        1'b0, 1'b0, CFG_KEEP,   1'b1, CNT_TRI,  32'h1, 32'h2, 32'h3},
        '{32'hDEAD_BEEF, 1'b0, 1'b1, CFG_KEEP,  1'b1, CNT_LIST, 32'hBEEF, 32'h0, 32'h0},
        '{ONES,         1'b0, 1'b1, CFG_KEEP,   1'b1, CNT_LIST, 32'hFFFF, 32'h0, 32'h0},
        // 0xFFFF is an ordinary index in wide mode
        '{32'h0000_FFFF, 1'b1, 1'b0, CFG_WIDE,  1'b1, CNT_NONE, 32'h0, 32'h0, 32'h0}
    };

    strip_to_triangle_list_core #(
        .INDEX_WIDTH(IDX_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] in_index
        .s_axis_tuser  (s_axis_tuser),   // [0] starts_segment, [1] is_list
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] out_index
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Stall the output at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Work out the indices one accepted request owes
    task automatic convert_index(input logic [31:0] raw, input logic seg, input logic lst);
        logic [31:0] m;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] res [3];
        int          n;
        m = mode_wide ? WIDE_MASK : NARROW_MASK;
        v = raw & m;
        n = 0;
        if (seg) begin
            hist     = '{ONES, ONES, ONES};
            flip_odd = 1'b0;
        end
        if (lst) begin
            res[0] = v;
            n      = 1;
        end else begin
            hist[0] = hist[1];
            hist[1] = hist[2];
            hist[2] = v;
            a = hist[0] & m;
            b = hist[1] & m;
            c = hist[2] & m;
            if (a == m || b == m || c == m) begin
                flip_odd = 1'b0;
            end else if (a != b && a != c && b != c) begin
                res[0]   = flip_odd ? b : a;
                res[1]   = flip_odd ? a : b;
                res[2]   = c;
                n        = 3;
                flip_odd = ~flip_odd;
            end
        end
        // Directed rows with hand-written results override the prediction
        if (cur_typed) begin
            n      = int'(cur_cnt);
            res[0] = cur_e0;
            res[1] = cur_e1;
            res[2] = cur_e2;
        end
        for (int i = 0; i < n; i++) begin
            owed_indices.push_back('{res[i], (i == n - 1)});
        end
    endtask

    // Track config, predict on each request, check each output index
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist      = '{ONES, ONES, ONES};
            flip_odd  = 1'b0;
            mode_wide = MODE_WIDE;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_indices.size() == 0) begin
                    $display("%0t: unexpected out_index, expected none, actual %h",
                             $time, m_axis_tdata);
                    n_err++;
                end else begin
                    got_rec = owed_indices.pop_front();
                    if (m_axis_tdata !== got_rec.idx) begin
                        $display("%0t: out_index mismatch, expected %h, actual %h",
                                 $time, got_rec.idx, m_axis_tdata);
                        n_err++;
                    end
                    if (m_axis_tlast !== got_rec.last) begin
                        $display("%0t: last_of_run mismatch, expected %b, actual %b",
                                 $time, got_rec.last, m_axis_tlast);
                        n_err++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                mode_wide = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                convert_index(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
            end
        end
    end

    // Present one request and hold it until accepted
    task automatic send_item(input logic [31:0] idx, input logic seg, input logic lst,
                             input bit typed, input logic [1:0] cnt,
                             input logic [31:0] e0, input logic [31:0] e1,
                             input logic [31:0] e2);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        s_axis_tuser  <= {lst, seg};
        cur_typed     <= typed;
        cur_cnt       <= cnt;
        cur_e0        <= e0;
        cur_e1        <= e1;
        cur_e2        <= e2;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait until every owed index is out and the pipeline has settled
    task automatic drain_outputs();
        @(posedge i_clk);
        while (owed_indices.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write wide_index with the block idle
    task automatic set_mode(input bit w);
        s_axis_tvalid <= 1'b0;
        drain_outputs();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        drv_wide = w;
    endtask

    // Mostly strips over a small index pool, with restarts, lists and noise
    task automatic pick_item(output logic [31:0] idx, output logic seg, output logic lst);
        logic [31:0] m;
        int          roll;
        m    = drv_wide ? WIDE_MASK : NARROW_MASK;
        seg  = ($urandom_range(0, 99) < 8);
        lst  = ($urandom_range(0, 99) < 12);
        roll = $urandom_range(0, 99);
        if (seg) begin
            strip_base = $urandom;
        end
        if (roll < 60) begin
            idx = ($urandom & ~m) | ((strip_base + 32'($urandom_range(0, 5))) & m);
        end else if (roll < 72) begin
            idx = ($urandom & ~m) | m;
        end else if (roll < 80) begin
            idx = ($urandom & ~m) | (m - 32'($urandom_range(1, 3)));
        end else begin
            idx = $urandom;
        end
    endtask

    initial begin
        logic [31:0] r_idx;
        logic        r_seg;
        logic        r_lst;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg == CFG_NARROW) begin
                set_mode(MODE_NARROW);
            end else if (dir_rows[i].cfg == CFG_WIDE) begin
                set_mode(MODE_WIDE);
            end
            send_item(dir_rows[i].idx, dir_rows[i].seg, dir_rows[i].lst,
                      dir_rows[i].typed, dir_rows[i].cnt,
                      dir_rows[i].e0, dir_rows[i].e1, dir_rows[i].e2);
        end

        // Random phases: alternate index width, step through idling profiles
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_mode(ph[0] ? MODE_WIDE : MODE_NARROW);
            case (ph / 2)
                0: begin
                    src_idle_pct  = 25;
                    sink_idle_pct = 76;
                end
                1: begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 25;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick_item(r_idx, r_seg, r_lst);
                send_item(r_idx, r_seg, r_lst, 1'b0, CNT_NONE, '0, '0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_outputs();
        if (n_err == 0 && owed_indices.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
